// ----- rtl/sandbox_resource_quota_monitor_macros.svh -----
// Assertion macros used by the sandbox resource quota monitor RTL.
// Included by srqm_core, which checks its own logic; depends on nothing else.
`ifndef SANDBOX_RESOURCE_QUOTA_MONITOR_MACROS_SVH
`define SANDBOX_RESOURCE_QUOTA_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRQM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SRQM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/srqm_pkg.sv -----
// Package of the sandbox resource quota monitor: event, limit and result types,
// event, status and register codes. Depends on nothing.
package srqm_pkg;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_DEALLOC = 3'd1;
   localparam logic [2:0] ACT_PUSH    = 3'd2;
   localparam logic [2:0] ACT_POP     = 3'd3;
   localparam logic [2:0] ACT_PERM    = 3'd4;
   localparam logic [2:0] ACT_INSTR   = 3'd5;
   localparam logic [2:0] ACT_TICK    = 3'd6;
   localparam logic [2:0] ACT_CLEAR   = 3'd7;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_PERM   = 3'd1;
   localparam logic [2:0] ST_SIZE   = 3'd2;
   localparam logic [2:0] ST_MEMORY = 3'd3;
   localparam logic [2:0] ST_COUNT  = 3'd4;
   localparam logic [2:0] ST_STACK  = 3'd5;
   localparam logic [2:0] ST_INSTR  = 3'd6;
   localparam logic [2:0] ST_TIME   = 3'd7;

   localparam logic [2:0] CSR_MAX_SINGLE_ALLOC = 3'd0;
   localparam logic [2:0] CSR_MAX_TOTAL_MEMORY = 3'd1;
   localparam logic [2:0] CSR_MAX_ALLOC_COUNT  = 3'd2;
   localparam logic [2:0] CSR_MAX_STACK_LEVELS = 3'd3;
   localparam logic [2:0] CSR_MAX_INSTR_COUNT  = 3'd4;
   localparam logic [2:0] CSR_MAX_TIME_MS      = 3'd5;
   localparam logic [2:0] CSR_PERMISSION_MASK  = 3'd6;

   localparam int CSR_DATA_W = 48;

   // Number of permissions that can be granted at all.
   localparam int PERM_COUNT = 16;
   localparam logic [15:0] PERM_VALID =
      (PERM_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PERM_COUNT) - 32'd1);

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] amount;
      logic [3:0]  perm_index;
   } srqm_event_type;

   typedef struct packed {
      logic [31:0] max_single_alloc;
      logic [47:0] max_total_memory;
      logic [31:0] max_alloc_count;
      logic [15:0] max_stack_levels;
      logic [31:0] max_instr_count;
      logic [31:0] max_time_ms;
      logic [15:0] permission_mask;
   } srqm_limits_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] bytes_held;
      logic [31:0] alloc_total;
      logic [15:0] stack_level;
      logic [15:0] stack_peak;
      logic [31:0] instr_total;
      logic [31:0] time_used_ms;
      logic [31:0] checks_done;
      logic [31:0] checks_denied;
   } srqm_result_type;

endpackage

// ----- rtl/srqm_req_if.sv -----
// Request channel of the sandbox resource quota monitor: valid, ready and one event.
// Depends on nothing.
interface srqm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] amount;
   logic [3:0]  perm_index;

   modport source (output valid, output action, output amount, output perm_index,
                   input ready);
   modport sink (input valid, input action, input amount, input perm_index,
                 output ready);
endinterface

// ----- rtl/srqm_rsp_if.sv -----
// Response channel of the sandbox resource quota monitor: valid, ready, status and
// usage counters. Depends on nothing.
interface srqm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [47:0] bytes_held;
   logic [31:0] alloc_total;
   logic [15:0] stack_level;
   logic [15:0] stack_peak;
   logic [31:0] instr_total;
   logic [31:0] time_used_ms;
   logic [31:0] checks_done;
   logic [31:0] checks_denied;

   modport source (output valid, output status, output bytes_held, output alloc_total,
                   output stack_level, output stack_peak, output instr_total,
                   output time_used_ms, output checks_done, output checks_denied,
                   input ready);
   modport sink (input valid, input status, input bytes_held, input alloc_total,
                 input stack_level, input stack_peak, input instr_total,
                 input time_used_ms, input checks_done, input checks_denied,
                 output ready);
endinterface

// ----- rtl/srqm_csr.sv -----
// Limit registers of the sandbox resource quota monitor, written through a plain port.
// Depends on srqm_pkg.
module srqm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [2:0]                        csr_index,
   input  logic [srqm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output srqm_pkg::srqm_limits_type         limits
);
   import srqm_pkg::*;

   localparam srqm_limits_type LIMITS_RESET = '{
      max_single_alloc: 32'd0,
      max_total_memory: 48'd0,
      max_alloc_count:  32'd0,
      max_stack_levels: 16'd0,
      max_instr_count:  32'hFFFF_FFFF,
      max_time_ms:      32'd0,
      permission_mask:  16'd0
   };

   srqm_limits_type limits_ff;
   srqm_limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_MAX_SINGLE_ALLOC: limits_in.max_single_alloc = csr_wdata[31:0];
            CSR_MAX_TOTAL_MEMORY: limits_in.max_total_memory = csr_wdata[47:0];
            CSR_MAX_ALLOC_COUNT:  limits_in.max_alloc_count  = csr_wdata[31:0];
            CSR_MAX_STACK_LEVELS: limits_in.max_stack_levels = csr_wdata[15:0];
            CSR_MAX_INSTR_COUNT:  limits_in.max_instr_count  = csr_wdata[31:0];
            CSR_MAX_TIME_MS:      limits_in.max_time_ms      = csr_wdata[31:0];
            CSR_PERMISSION_MASK:  limits_in.permission_mask  = csr_wdata[15:0];
            default:              limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= LIMITS_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;
endmodule

// ----- rtl/srqm_core.sv -----
// Request register and usage counters of the sandbox resource quota monitor; checks one event per
// cycle against the limits while out_ready is high. Depends on srqm_pkg and the assertion macros.
`include "sandbox_resource_quota_monitor_macros.svh"

module srqm_core #(
   parameter int TIME_CHECK_PERIOD = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  srqm_pkg::srqm_event_type   in_event,
   input  srqm_pkg::srqm_limits_type  limits,
   output logic                       out_valid,
   input  logic                       out_ready,
   output srqm_pkg::srqm_result_type  out_result
);
   import srqm_pkg::*;

   localparam int RES_W = (TIME_CHECK_PERIOD > 1) ? $clog2(TIME_CHECK_PERIOD) : 1;
   localparam logic [RES_W-1:0] RES_LAST = RES_W'(TIME_CHECK_PERIOD - 1);

   logic            ev_valid_ff;
   srqm_event_type  ev_ff;
   logic            fire;

   logic [47:0]      held_bytes_ff, held_bytes_in;
   logic [31:0]      alloc_counter_ff, alloc_counter_in;
   logic [15:0]      depth_now_ff, depth_now_in;
   logic [15:0]      depth_peak_ff, depth_peak_in;
   logic [31:0]      instr_counter_ff, instr_counter_in;
   logic [RES_W-1:0] residue_ff, residue_in;
   logic [31:0]      ms_counter_ff, ms_counter_in;
   logic [31:0]      perm_checks_ff, perm_checks_in;
   logic [31:0]      perm_denials_ff, perm_denials_in;

   logic [48:0] sum;
   logic [47:0] amount_w;
   logic [15:0] depth_up;
   logic        granted;
   logic [2:0]  status;

   assign fire     = ev_valid_ff && out_ready;
   assign in_ready = !ev_valid_ff || out_ready;
   assign out_valid = ev_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (in_ready) begin
         ev_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ev_ff <= in_event;
      end
   end

   assign amount_w = {16'd0, ev_ff.amount};
   assign sum      = {1'b0, held_bytes_ff} + {1'b0, amount_w};
   assign depth_up = depth_now_ff + 16'(depth_now_ff != '1);
   assign granted  = PERM_VALID[ev_ff.perm_index] & limits.permission_mask[ev_ff.perm_index];

   always_comb begin
      held_bytes_in    = held_bytes_ff;
      alloc_counter_in = alloc_counter_ff;
      depth_now_in     = depth_now_ff;
      depth_peak_in    = depth_peak_ff;
      instr_counter_in = instr_counter_ff;
      residue_in       = residue_ff;
      ms_counter_in    = ms_counter_ff;
      perm_checks_in   = perm_checks_ff;
      perm_denials_in  = perm_denials_ff;
      status           = ST_OK;
      unique case (ev_ff.action)
         ACT_ALLOC: begin
            if (limits.max_single_alloc != '0 &&
                ev_ff.amount > limits.max_single_alloc) begin
               status = ST_SIZE;
            end else if (limits.max_total_memory != '0 &&
                         sum > {1'b0, limits.max_total_memory}) begin
               status = ST_MEMORY;
            end else if (limits.max_alloc_count != '0 &&
                         alloc_counter_ff >= limits.max_alloc_count) begin
               status = ST_COUNT;
            end else begin
               held_bytes_in    = sum[48] ? '1 : sum[47:0];
               alloc_counter_in = alloc_counter_ff + 32'(alloc_counter_ff != '1);
            end
         end
         ACT_DEALLOC: begin
            held_bytes_in = (amount_w >= held_bytes_ff) ? '0 : held_bytes_ff - amount_w;
         end
         ACT_PUSH: begin
            if (limits.max_stack_levels != '0 &&
                depth_now_ff >= limits.max_stack_levels) begin
               status = ST_STACK;
            end else begin
               depth_now_in = depth_up;
               if (depth_up > depth_peak_ff) begin
                  depth_peak_in = depth_up;
               end
            end
         end
         ACT_POP: begin
            depth_now_in = depth_now_ff - 16'(depth_now_ff != '0);
         end
         ACT_PERM: begin
            perm_checks_in = perm_checks_ff + 32'(perm_checks_ff != '1);
            if (!granted) begin
               perm_denials_in = perm_denials_ff + 32'(perm_denials_ff != '1);
               status          = ST_PERM;
            end
         end
         ACT_INSTR: begin
            if (instr_counter_ff >= limits.max_instr_count) begin
               status = ST_INSTR;
            end else if (residue_ff == '0 && limits.max_time_ms != '0 &&
                         ms_counter_ff >= limits.max_time_ms) begin
               status = ST_TIME;
            end else begin
               instr_counter_in = instr_counter_ff + 32'(instr_counter_ff != '1);
               residue_in       = (residue_ff == RES_LAST) ? '0 : residue_ff + 1'b1;
            end
         end
         ACT_TICK: begin
            ms_counter_in = ms_counter_ff + 32'(ms_counter_ff != '1);
         end
         ACT_CLEAR: begin
            held_bytes_in    = '0;
            alloc_counter_in = '0;
            depth_now_in     = '0;
            depth_peak_in    = '0;
            instr_counter_in = '0;
            residue_in       = '0;
            ms_counter_in    = '0;
            perm_checks_in   = '0;
            perm_denials_in  = '0;
         end
         default: status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff    <= '0;
         alloc_counter_ff <= '0;
         depth_now_ff     <= '0;
         depth_peak_ff    <= '0;
         instr_counter_ff <= '0;
         residue_ff       <= '0;
         ms_counter_ff    <= '0;
         perm_checks_ff   <= '0;
         perm_denials_ff  <= '0;
      end else if (fire) begin
         held_bytes_ff    <= held_bytes_in;
         alloc_counter_ff <= alloc_counter_in;
         depth_now_ff     <= depth_now_in;
         depth_peak_ff    <= depth_peak_in;
         instr_counter_ff <= instr_counter_in;
         residue_ff       <= residue_in;
         ms_counter_ff    <= ms_counter_in;
         perm_checks_ff   <= perm_checks_in;
         perm_denials_ff  <= perm_denials_in;
      end
   end

   assign out_result.status        = status;
   assign out_result.bytes_held    = held_bytes_in;
   assign out_result.alloc_total   = alloc_counter_in;
   assign out_result.stack_level   = depth_now_in;
   assign out_result.stack_peak    = depth_peak_in;
   assign out_result.instr_total   = instr_counter_in;
   assign out_result.time_used_ms  = ms_counter_in;
   assign out_result.checks_done   = perm_checks_in;
   assign out_result.checks_denied = perm_denials_in;

   `SRQM_ASSERT_IMP(a_peak_covers_depth, clock, reset, 1'b1, depth_peak_ff >= depth_now_ff, "stack peak is below the current depth")
   `SRQM_ASSERT_IMP(a_residue_in_step, clock, reset, instr_counter_ff == '0, residue_ff == '0, "time check phase out of step with the instruction count")
   `SRQM_ASSERT_NXT(a_held_stable, clock, reset, !fire, $stable(held_bytes_ff), "bytes held changed without a request")
   `SRQM_ASSERT_NXT(a_alloc_only, clock, reset, fire && ev_ff.action != ACT_ALLOC && ev_ff.action != ACT_CLEAR, $stable(alloc_counter_ff), "allocation count changed on another request")
endmodule

// ----- rtl/srqm_out_reg.sv -----
// Result register of the sandbox resource quota monitor; holds one response while the
// consumer stalls. Depends on srqm_pkg.
module srqm_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  srqm_pkg::srqm_result_type  in_result,
   output logic                       out_valid,
   input  logic                       out_ready,
   output srqm_pkg::srqm_result_type  out_result
);
   import srqm_pkg::*;

   logic            valid_ff;
   srqm_result_type result_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
endmodule

// ----- rtl/sandbox_resource_quota_monitor.sv -----
// Top level of the sandbox resource quota monitor: limit registers, event core and
// result register. Depends on srqm_pkg, the two channel interfaces and the submodules.
//
//   port     direction  carries
//   req_ch   in         one event: action, amount, perm_index
//   rsp_ch   out        status and the usage counters after that event
//   csr_*    in         write of one limit register
//
// One request is taken in every cycle unless the response side stalls; its response passes
// through the request register, the single checking stage and then the result register.
// Synchronous reset clears all counters and returns the limits to their reset values.
// A stall on the response side holds both registers; two requests are buffered at most.
module sandbox_resource_quota_monitor #(
   parameter int TIME_CHECK_PERIOD = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   srqm_req_if.sink                          req_ch,
   srqm_rsp_if.source                        rsp_ch,
   input  logic                              csr_wen,
   input  logic [2:0]                        csr_index,
   input  logic [srqm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srqm_pkg::*;

   srqm_limits_type limits;
   srqm_event_type  req_event;
   srqm_result_type core_result;
   srqm_result_type rsp_result;
   logic            core_valid;
   logic            core_ready;

   assign req_event.action     = req_ch.action;
   assign req_event.amount     = req_ch.amount;
   assign req_event.perm_index = req_ch.perm_index;

   srqm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   srqm_core #(
      .TIME_CHECK_PERIOD (TIME_CHECK_PERIOD)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_event   (req_event),
      .limits     (limits),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_result (core_result)
   );

   srqm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (core_valid),
      .in_ready   (core_ready),
      .in_result  (core_result),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_result (rsp_result)
   );

   assign rsp_ch.status        = rsp_result.status;
   assign rsp_ch.bytes_held    = rsp_result.bytes_held;
   assign rsp_ch.alloc_total   = rsp_result.alloc_total;
   assign rsp_ch.stack_level   = rsp_result.stack_level;
   assign rsp_ch.stack_peak    = rsp_result.stack_peak;
   assign rsp_ch.instr_total   = rsp_result.instr_total;
   assign rsp_ch.time_used_ms  = rsp_result.time_used_ms;
   assign rsp_ch.checks_done   = rsp_result.checks_done;
   assign rsp_ch.checks_denied = rsp_result.checks_denied;
endmodule
